// File: hdl/qs_pkg.sv
package qs_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t sample_value;
    logic   is_last;
  } in_item_t;

  typedef struct packed {
    value_t sorted_value;
    logic   final_flag;
    logic   overflow;
  } out_item_t;

endpackage

// File: hdl/qs_ram.sv
module qs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/quicksort_engine.sv
// Load: one item per cycle into the element store; in_stall_o stays low while loading.
// Sort: Lomuto partition with the last element of a range as pivot, on one
//   store with one write and one read port, and one shared compare; each scanned
//   element is read and compared, and each swap reads and writes the store.
// Emit: stalls hold a result; the next set is taken after the final result leaves.
// Reset: state, counts and flags clear at once; store and range stack hold no reset.
module quicksort_engine
  import qs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW = 2 * AW;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RDPIV,
    S_PIV,
    S_RDJ,
    S_CMPJ,
    S_RDI,
    S_WRJ,
    S_FRDI,
    S_FWRH,
    S_POP,
    S_POPW,
    S_ERD,
    S_ELD,
    S_EHOLD
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic dropped_q, dropped_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW-1:0] sp_q, sp_d;
  value_t pivot_q, pivot_d, aj_q, aj_d, tmp_q, tmp_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  value_t        e_wdata, e_rdata;
  logic          s_we;
  logic [AW-1:0] s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic          full;
  logic [CW-1:0] new_count;
  logic [AW-1:0] last_idx;
  logic          left_small, push_right, push_left;

  qs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  qs_ram #(.WIDTH(SW), .DEPTH(MAX_ELEMENTS)) u_stack (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(sp_q),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  assign full       = (count_q == CW'(MAX_ELEMENTS));
  assign new_count  = full ? count_q : count_q + CW'(1);
  assign last_idx   = AW'(count_q - CW'(1));
  assign left_small = (i_q - lo_q) < (hi_q - i_q);
  assign push_right = ({1'b0, i_q} + (AW+1)'(1)) < {1'b0, hi_q};
  assign push_left  = ({1'b0, lo_q} + (AW+1)'(1)) < {1'b0, i_q};
  assign s_wdata    = left_small ? {i_q + AW'(1), hi_q} : {lo_q, i_q - AW'(1)};
  assign s_raddr    = sp_q - AW'(1);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = i_q;
    e_wdata = aj_q;
    e_raddr = '0;
    case (state_q)
      S_LOAD: begin
        e_we    = in_valid_i && !full;
        e_waddr = count_q[AW-1:0];
        e_wdata = in_data_i.sample_value;
      end
      S_RDPIV: e_raddr = hi_q;
      S_RDJ:   e_raddr = (j_q == hi_q) ? i_q : j_q;
      S_CMPJ:  e_raddr = i_q;
      S_RDI: begin
        e_we    = 1'b1;
        e_waddr = i_q;
        e_wdata = aj_q;
      end
      S_WRJ: begin
        e_we    = 1'b1;
        e_waddr = j_q;
        e_wdata = tmp_q;
      end
      S_FRDI: begin
        e_we    = 1'b1;
        e_waddr = i_q;
        e_wdata = pivot_q;
      end
      S_FWRH: begin
        e_we    = 1'b1;
        e_waddr = hi_q;
        e_wdata = tmp_q;
      end
      S_ERD:   e_raddr = k_q;
      S_EHOLD: e_raddr = k_q + AW'(1);
      default: e_raddr = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    sp_d        = sp_q;
    pivot_d     = pivot_q;
    aj_d        = aj_q;
    tmp_d       = tmp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    s_we        = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          count_d = new_count;
          if (full) begin
            dropped_d = 1'b1;
          end
          if (in_data_i.is_last) begin
            lo_d = '0;
            hi_d = AW'(new_count - CW'(1));
            sp_d = '0;
            k_d  = '0;
            state_d = (new_count >= CW'(2)) ? S_RDPIV : S_ERD;
          end
        end
      end
      S_RDPIV: state_d = S_PIV;
      S_PIV: begin
        pivot_d = e_rdata;
        i_d     = lo_q;
        j_d     = lo_q;
        state_d = S_RDJ;
      end
      S_RDJ: state_d = (j_q == hi_q) ? S_FRDI : S_CMPJ;
      S_CMPJ: begin
        if (e_rdata <= pivot_q) begin
          if (i_q == j_q) begin
            i_d     = i_q + AW'(1);
            j_d     = j_q + AW'(1);
            state_d = S_RDJ;
          end else begin
            aj_d    = e_rdata;
            state_d = S_RDI;
          end
        end else begin
          j_d     = j_q + AW'(1);
          state_d = S_RDJ;
        end
      end
      S_RDI: begin
        tmp_d   = e_rdata;
        state_d = S_WRJ;
      end
      S_WRJ: begin
        i_d     = i_q + AW'(1);
        j_d     = j_q + AW'(1);
        state_d = S_RDJ;
      end
      S_FRDI: begin
        tmp_d   = e_rdata;
        state_d = S_FWRH;
      end
      S_FWRH: begin
        if (left_small) begin
          s_we    = push_right;
          hi_d    = i_q - AW'(1);
          state_d = push_left ? S_RDPIV : S_POP;
          if (push_right) begin
            sp_d = sp_q + AW'(1);
          end
        end else begin
          s_we    = push_left;
          lo_d    = i_q + AW'(1);
          state_d = push_right ? S_RDPIV : S_POP;
          if (push_left) begin
            sp_d = sp_q + AW'(1);
          end
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          state_d = S_ERD;
        end else begin
          sp_d    = sp_q - AW'(1);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        lo_d    = s_rdata[SW-1:AW];
        hi_d    = s_rdata[AW-1:0];
        state_d = S_RDPIV;
      end
      S_ERD: state_d = S_ELD;
      S_ELD: begin
        out_d.sorted_value = e_rdata;
        out_d.final_flag   = (k_q == last_idx);
        out_d.overflow     = dropped_q;
        out_valid_d        = 1'b1;
        state_d            = S_EHOLD;
      end
      S_EHOLD: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_q.final_flag) begin
            count_d   = '0;
            dropped_d = 1'b0;
            k_d       = '0;
            state_d   = S_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_ELD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    pivot_q <= pivot_d;
    aj_q    <= aj_d;
    tmp_q   <= tmp_d;
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result pending while accepting items");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store size");

  a_final_returns_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.final_flag |=> !in_stall_o && count_q == '0)
    else $error("engine did not return to load after final result");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMPJ || state_q == S_RDI || state_q == S_WRJ) |->
      (i_q <= j_q && j_q < hi_q && lo_q <= i_q))
    else $error("partition pointers out of order");

endmodule

// File: tb/tb_quicksort_engine.sv
module tb_quicksort_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import qs_pkg::*;

  localparam int STORE_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_ROWS         = 21;
  localparam int N_PHASES       = 4;
  localparam int SETS_PER_PHASE = 3;

  localparam value_t MAX_V = 32'sh7fffffff;
  localparam value_t MIN_V = 32'sh80000000;

  localparam int TX_PCT [N_PHASES] = '{0, 70, 0, 33};
  localparam int RX_PCT [N_PHASES] = '{0, 0, 70, 33};

  typedef struct {
    value_t value;
    logic   last;
    int     rep;
    bit     typed;
    value_t tval;
    logic   tovf;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  stim_row_t rows [N_ROWS];

  // running set: kept in ascending order as items arrive
  value_t    set_vals [STORE_DEPTH];
  int        set_cnt     = 0;
  logic      set_dropped = 1'b0;
  out_item_t sorted_q [$];
  out_item_t exp_item;

  int tx_pct          = 0;
  int rx_pct          = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int sets_done       = 0;
  int results_checked = 0;
  int idle_cycles     = 0;

  quicksort_engine #(.MAX_ELEMENTS(STORE_DEPTH)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic absorb_sample(input in_item_t it, input bit typed, input value_t tval,
                               input logic tovf);
    value_t    v;
    int        j;
    out_item_t e;
    if (set_cnt < STORE_DEPTH) begin
      v = it.sample_value;
      j = set_cnt;
      while (j > 0 && set_vals[j-1] > v) begin
        set_vals[j] = set_vals[j-1];
        j--;
      end
      set_vals[j] = v;
      set_cnt++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.is_last) begin
      for (int k = 0; k < set_cnt; k++) begin
        e.sorted_value = typed ? tval : set_vals[k];
        e.final_flag   = (k == set_cnt - 1);
        e.overflow     = typed ? tovf : set_dropped;
        sorted_q.push_back(e);
      end
      set_cnt     = 0;
      set_dropped = 1'b0;
      sets_done++;
    end
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input value_t tval,
                           input logic tovf);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    absorb_sample(it, typed, tval, tovf);
    items_sent++;
    if ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_pct);
    end
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < rx_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d final %0b overflow %0b",
                   out_data_o.sorted_value, out_data_o.final_flag, out_data_o.overflow);
      end else begin
        exp_item = sorted_q.pop_front();
        if (out_data_o.sorted_value !== exp_item.sorted_value ||
            out_data_o.final_flag !== exp_item.final_flag ||
            out_data_o.overflow !== exp_item.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     exp_item.sorted_value, exp_item.final_flag, exp_item.overflow,
                     out_data_o.sorted_value, out_data_o.final_flag, out_data_o.overflow);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int       n;
    rows[0]  = '{MAX_V, 1'b1, 1, 1'b1, MAX_V, 1'b0};
    rows[1]  = '{MIN_V, 1'b1, 1, 1'b1, MIN_V, 1'b0};
    rows[2]  = '{32'sd0, 1'b1, 1, 1'b1, 32'sd0, 1'b0};
    rows[3]  = '{-32'sd1, 1'b1, 1, 1'b1, -32'sd1, 1'b0};
    rows[4]  = '{32'sd5, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[5]  = '{-32'sd3, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[6]  = '{MAX_V, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[7]  = '{MIN_V, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[8]  = '{32'sd0, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[9]  = '{-32'sd1, 1'b1, 1, 1'b0, 32'sd0, 1'b0};
    rows[10] = '{32'sd7, 1'b1, 2, 1'b1, 32'sd7, 1'b0};
    rows[11] = '{32'sd3, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[12] = '{32'sd2, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[13] = '{32'sd1, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[14] = '{32'sd0, 1'b1, 1, 1'b0, 32'sd0, 1'b0};
    // store filled exactly, then one past capacity with the last mark on the dropped item
    rows[15] = '{32'sd42, 1'b1, STORE_DEPTH, 1'b1, 32'sd42, 1'b0};
    rows[16] = '{-32'sd9, 1'b1, STORE_DEPTH + 1, 1'b1, -32'sd9, 1'b1};
    rows[17] = '{32'sd100, 1'b0, 1, 1'b0, 32'sd0, 1'b0};
    rows[18] = '{-32'sd100, 1'b1, 1, 1'b0, 32'sd0, 1'b0};
    rows[19] = '{32'sh55555555, 1'b1, 1, 1'b1, 32'sh55555555, 1'b0};
    rows[20] = '{32'shaaaaaaaa, 1'b1, 1, 1'b1, 32'shaaaaaaaa, 1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      for (int k = 0; k < rows[i].rep; k++) begin
        it.sample_value = rows[i].value;
        it.is_last      = rows[i].last && (k == rows[i].rep - 1);
        send_item(it, rows[i].typed, rows[i].tval, rows[i].tovf);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_pct = TX_PCT[ph];
      rx_pct = RX_PCT[ph];
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(7))
            0:       it.sample_value = MAX_V;
            1:       it.sample_value = MIN_V;
            2, 3:    it.sample_value = $urandom_range(8) - 4;
            default: it.sample_value = $urandom;
          endcase
          it.is_last = (k == n - 1);
          send_item(it, 1'b0, 32'sd0, 1'b0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d sets from %0d items sorted, %0d results checked", sets_done, items_sent,
             results_checked);
    $display("covered extremes, duplicates, single items, full store, dropped items, stalls");
    if (mismatches == 0 && sorted_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
